### sv/adcra_pkg.sv
// shared types and constants for the adc ring moving average block
package adcra_pkg;

    // fixed by the channel count of the converter front end
    localparam int CHANNELS = 4;
    localparam int SAMPLE_W = 8;
    localparam int LANE_W   = 2;
    localparam int ROW_W    = CHANNELS * SAMPLE_W;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
        logic [SAMPLE_W-1:0] sample_ch3;
        logic [2:0]          read_channel;
    } req_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                channel_error;
    } rsp_item_t;

endpackage

### sv/adcra_ram.sv
// generic single write port ram with registered read
module adcra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/adc_ring_moving_average.sv
// top level: four-channel sample ring with windowed average readout
// store beat: one ram row write (all channels side by side); the block stays ready for the next beat
// read beat, valid channel: the window is walked (S_WALK), divided (S_DIV) and handed out (S_DONE),
//   and the block takes a new beat in the same cycle that rsp_valid rises; one ram row read per cycle
//   over the window and one reciprocal multiply by AVG_COUNT
// read beat, bad channel: goes straight to S_DONE, skipping walk and divide; a held output adds its wait
// reset: async active low; row valid flags cleared at once, unwritten rows read zero
module adc_ring_moving_average
    import adcra_pkg::*;
#(
    parameter int BUF_DEPTH = 16,
    parameter int AVG_COUNT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int POS_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(AVG_COUNT + 1);
    // sum of AVG_COUNT bytes stays below 256 * AVG_COUNT
    localparam int SUM_W = SAMPLE_W + $clog2(AVG_COUNT);
    // floor(sum / AVG_COUNT) as (sum * REC_M) >> REC_SH, exact over the whole sum range
    localparam int REC_SH = SUM_W + $clog2(AVG_COUNT);
    localparam int REC_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + REC_W;
    localparam logic [REC_W-1:0] REC_M =
        REC_W'(((64'd1 << REC_SH) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUF_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [POS_W-1:0]     wr_pos_reg;
    logic [POS_W-1:0]     wr_pos_next;
    logic [BUF_DEPTH-1:0] row_valid_reg;
    logic [POS_W-1:0]     rd_pos_reg;
    logic [LANE_W-1:0]    lane_reg;
    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 acc_en_reg;
    logic                 hit_valid_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SAMPLE_W-1:0]  quot_reg;
    logic                 err_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg;

    logic                 req_fire;
    logic                 store_fire;
    logic                 issue;
    logic [ROW_W-1:0]     row_rdata;
    logic [SAMPLE_W-1:0]  lane_byte;
    logic [PROD_W-1:0]    div_prod;
    logic                 rsp_free;

    assign req_ready  = (state_reg == S_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign store_fire = req_fire && (req.opcode == OP_STORE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign rsp_free   = !rsp_valid_reg || rsp_ready;

    // ring write position advances before the row is written
    assign wr_pos_next = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + POS_W'(1);

    // one read per cycle while the window is not yet fully issued
    assign issue = (state_reg == S_WALK) && (issue_cnt_reg != CNT_W'(AVG_COUNT));

    // sample ring: one row per write position, channel 0 in the low lane
    adcra_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (store_fire),
        .waddr (wr_pos_next),
        .wdata ({req.sample_ch3, req.sample_ch2, req.sample_ch1, req.sample_ch0}),
        .raddr (rd_pos_reg),
        .rdata (row_rdata)
    );

    // a row never written since reset counts as zero
    assign lane_byte = hit_valid_reg ? row_rdata[lane_reg*SAMPLE_W +: SAMPLE_W] : '0;

    // reciprocal multiply, quotient known to fit in one byte
    assign div_prod = {{REC_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, REC_M};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_pos_reg    <= '0;
            row_valid_reg <= '0;
            rd_pos_reg    <= '0;
            lane_reg      <= '0;
            issue_cnt_reg <= '0;
            acc_en_reg    <= 1'b0;
            hit_valid_reg <= 1'b0;
            sum_reg       <= '0;
            quot_reg      <= '0;
            err_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // the done step reloads the slot itself
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            // data of the previous issue arrives now
            acc_en_reg <= issue;
            if (issue)
            begin
                hit_valid_reg <= row_valid_reg[rd_pos_reg];
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                rd_pos_reg    <= (rd_pos_reg == '0) ? LAST_POS : rd_pos_reg - POS_W'(1);
            end
            if (acc_en_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(lane_byte);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (store_fire)
                    begin
                        wr_pos_reg                 <= wr_pos_next;
                        row_valid_reg[wr_pos_next] <= 1'b1;
                    end
                    else if (req_fire)
                    begin
                        if (req.read_channel >= 3'(CHANNELS))
                        begin
                            quot_reg  <= '0;
                            err_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            lane_reg      <= req.read_channel[LANE_W-1:0];
                            rd_pos_reg    <= wr_pos_reg;
                            issue_cnt_reg <= '0;
                            sum_reg       <= '0;
                            err_reg       <= 1'b0;
                            state_reg     <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (!issue && !acc_en_reg)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    quot_reg  <= div_prod[REC_SH +: SAMPLE_W];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait until the output slot is free
                    if (rsp_free)
                    begin
                        rsp_reg.average       <= quot_reg;
                        rsp_reg.channel_error <= err_reg;
                        rsp_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // window sum never exceeds AVG_COUNT full-scale samples
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |->
        (sum_reg <= SUM_W'(((1 << SAMPLE_W) - 1) * AVG_COUNT)))
        else $error("window sum out of range");

    // ram data is only accumulated inside a window walk
    a_acc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> (state_reg == S_WALK))
        else $error("accumulate outside walk");

    // never more reads than the window holds
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CNT_W'(AVG_COUNT))
        else $error("window overrun");

    // an error beat carries a zero average
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.channel_error) |-> (rsp.average == '0))
        else $error("error beat with nonzero average");

endmodule
